// ----- hdl/e2g_pkg.sv -----
// ----------------------------------------------------------------------------
// e2g_pkg - shared constants for the ECEF to geodetic converter
// Field widths, CORDIC constants, register indexes and the arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package e2g_pkg;

    // field widths
    localparam int COORD_W    = 36;
    localparam int FRAC_W     = 20;
    localparam int ANG_W      = 32;
    localparam int HGT_W      = 36;
    localparam int PASS_W     = 4;
    localparam int A_W        = 23;
    localparam int E2_W       = 26;
    localparam int IT_W       = 4;
    localparam int TOL_W      = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // CORDIC
    localparam int          CORDIC_STEPS = 30;
    localparam logic [31:0] INVK32       = 32'h9B74_EDA8;
    localparam logic [31:0] INVK30       = 32'd652032874;

    // register reset values
    localparam logic [A_W-1:0]   A_RESET   = 23'd6378245;
    localparam logic [E2_W-1:0]  E2_RESET  = 26'd28748027;
    localparam logic [IT_W-1:0]  IT_RESET  = 4'd10;
    localparam logic [TOL_W-1:0] TOL_RESET = 8'd7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEMI_MAJOR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECC_SQ     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 8'd3;

    // arctan(2^-i) with 2^31 = pi
    function automatic logic [29:0] angle_tab(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000029;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000003;
            5'd29: v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/e2g_if.sv -----
// ----------------------------------------------------------------------------
// e2g_if - channel interfaces of the ECEF to geodetic converter
// Position requests in, geodetic results out, and the register write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface e2g_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [e2g_pkg::COORD_W-1:0]  x_mm;
    logic signed [e2g_pkg::COORD_W-1:0]  y_mm;
    logic signed [e2g_pkg::COORD_W-1:0]  z_mm;
    modport source (output valid, x_mm, y_mm, z_mm, input ready);
    modport sink   (input valid, x_mm, y_mm, z_mm, output ready);
endinterface

interface e2g_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [e2g_pkg::ANG_W-1:0]   latitude;
    logic signed [e2g_pkg::ANG_W-1:0]   longitude;
    logic signed [e2g_pkg::HGT_W-1:0]   height_mm;
    logic        [e2g_pkg::PASS_W-1:0]  passes_used;
    logic                               converged;
    modport source (output valid, latitude, longitude, height_mm, passes_used, converged,
                    input ready);
    modport sink   (input valid, latitude, longitude, height_mm, passes_used, converged,
                    output ready);
endinterface

interface e2g_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [e2g_pkg::CFG_IDX_W-1:0]       index;
    logic [e2g_pkg::CFG_DATA_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/ecef_to_geodetic_top.sv -----
// ----------------------------------------------------------------------------
// ecef_to_geodetic_top - iterative ECEF to geodetic converter
// One shared CORDIC stage, one 32x33 multiplier, a bit-serial square root and
// a bit-serial divider run under a sequencer to refine latitude.
// ----------------------------------------------------------------------------
//  channel   dir   carries
//  i_in      in    x_mm, y_mm, z_mm position request
//  o_out     out   latitude, longitude, height_mm, passes_used, converged
//  i_cfg     in    register index and write data
//
//  Sequence: each refinement pass is set by the CORDIC stage (30 steps per
//  angle), the divider (66 steps) and the root (31 steps), all run one after
//  the other; the final divide is skipped when the final cosine is not
//  positive.
//  Reset: synchronous, active low; registers return to their reset values.
//  Stalls: the result sits in an output register, so a new request is taken
//  while it waits; the block holds its finished result if that is still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecef_to_geodetic_top (
    input  wire           i_clk,
    input  wire           i_rst_n,
    e2g_in_if.sink        i_in,
    e2g_out_if.source     o_out,
    e2g_cfg_if.sink       i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE, S_VEC_PRE, S_CORDIC, S_MUL_LO, S_MUL_HI, S_MUL_ADD, S_SQRT, S_DIV,
        S_LON_DONE, S_P_DONE, S_LAT_DONE, S_PASS, S_SC_DONE, S_S2_DONE, S_T_DONE,
        S_Q_DONE, S_R_DONE, S_AM_DONE, S_N_DONE, S_M_DONE, S_CORR_DONE, S_B1_DONE,
        S_FIN, S_FC_DONE, S_QC_DONE, S_HGT
    } t_state;

    localparam logic signed [59:0] Q30_P  = 60'sd1073741824;
    localparam logic signed [59:0] Q30_N  = -60'sd1073741824;
    localparam logic [65:0]        LIMIT  = 66'd137438953472;
    localparam logic signed [38:0] H_MAX  = 39'sd34359738367;
    localparam logic signed [38:0] H_MIN  = -39'sd34359738368;

    // registers
    logic [e2g_pkg::A_W-1:0]    r_a;
    logic [e2g_pkg::E2_W-1:0]   r_e2;
    logic [e2g_pkg::IT_W-1:0]   r_max;
    logic [e2g_pkg::TOL_W-1:0]  r_tol;

    t_state r_state, r_ret;
    logic [6:0] r_cnt;

    // CORDIC stage
    logic signed [59:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic               r_vec, r_vzero;

    // multiplier
    logic [63:0] r_ma;
    logic [32:0] r_mb;
    logic [64:0] r_pp_lo, r_pp_hi;
    logic [96:0] r_prod;

    // root
    logic [61:0] r_sq_v;
    logic [32:0] r_sq_rem;
    logic [30:0] r_sq_root;

    // divider
    logic [65:0] r_dv_n, r_dv_q;
    logic [30:0] r_dv_rem, r_dv_d;

    // loop values
    logic signed [55:0] r_zz;
    logic [55:0]        r_p;
    logic [31:0]        r_lon;
    logic signed [31:0] r_b;
    logic [30:0]        r_sabs;
    logic               r_sneg;
    logic [53:0]        r_n;
    logic [3:0]         r_k, r_iters, r_passes;
    logic               r_conv;
    logic [37:0]        r_qv;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_o_lat, r_o_lon;
    logic signed [35:0] r_o_hgt;
    logic [3:0]         r_o_pass;
    logic               r_o_conv;

    function automatic logic signed [31:0] clamp_q30(input logic signed [59:0] v);
        logic signed [59:0] c;
        c = (v > Q30_P) ? Q30_P : ((v < Q30_N) ? Q30_N : v);
        return c[31:0];
    endfunction

    // one CORDIC micro-rotation, shared by vectoring and rotation
    logic               sel;
    logic signed [59:0] xs, ys, n_cx, n_cy;
    logic signed [33:0] tab, n_cz;
    always_comb begin
        sel  = r_vec ? !(r_cy > 60'sd0) : (r_cz >= 34'sd0);
        ys   = r_cy >>> r_cnt[4:0];
        xs   = r_cx >>> r_cnt[4:0];
        tab  = $signed({4'd0, e2g_pkg::angle_tab(r_cnt[4:0])});
        n_cx = sel ? r_cx - ys : r_cx + ys;
        n_cy = sel ? r_cy + xs : r_cy - xs;
        n_cz = sel ? r_cz - tab : r_cz + tab;
    end

    // shared multiplier, low half then high half of A
    logic [31:0] mul_a;
    logic [64:0] mul_p;
    always_comb begin
        mul_a = (r_state == S_MUL_LO) ? r_ma[31:0] : r_ma[63:32];
        mul_p = {33'd0, mul_a} * {32'd0, r_mb};
    end

    // root step
    logic [34:0] sq_sh, sq_trial;
    logic        sq_ge;
    always_comb begin
        sq_sh    = {r_sq_rem, r_sq_v[61:60]};
        sq_trial = {2'd0, r_sq_root, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
    end

    // divider step
    logic [31:0] dv_t;
    logic        dv_ge;
    logic [31:0] dv_sub;
    always_comb begin
        dv_t   = {r_dv_rem, r_dv_n[65]};
        dv_ge  = dv_t >= {1'b0, r_dv_d};
        dv_sub = dv_t - {1'b0, r_dv_d};
    end

    // angle results, sine and cosine
    logic signed [31:0] lat_ang, sin_q, cos_q, sabs32;
    logic signed [32:0] d_ang, d_abs;
    always_comb begin
        lat_ang = clamp_q30(r_vzero ? 60'sd0 : {{28{r_cz[31]}}, r_cz[31:0]});
        sin_q   = clamp_q30(r_cy);
        cos_q   = clamp_q30(r_cx);
        sabs32  = sin_q[31] ? -sin_q : sin_q;
        d_ang   = {lat_ang[31], lat_ang} - {r_b[31], r_b};
        d_abs   = d_ang[32] ? -d_ang : d_ang;
    end

    // latitude correction and height
    logic [47:0]        corr;
    logic signed [56:0] corr_s, num;
    logic [30:0]        sq_w;
    logic signed [38:0] hd;
    logic signed [38:0] hgt;
    always_comb begin
        corr   = r_prod[79:32];
        corr_s = r_sneg ? -$signed({9'd0, corr}) : $signed({9'd0, corr});
        num    = {r_zz[55], r_zz} + corr_s;
        sq_w   = 31'd1073741824 - {7'd0, r_prod[55:32]};
        hd     = $signed({1'b0, r_qv}) - $signed({5'd0, r_n[53:20]});
        hgt    = (hd > H_MAX) ? H_MAX : ((hd < H_MIN) ? H_MIN : hd);
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.latitude    = r_o_lat;
    assign o_out.longitude   = r_o_lon;
    assign o_out.height_mm   = r_o_hgt;
    assign o_out.passes_used = r_o_pass;
    assign o_out.converged   = r_o_conv;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_a         <= e2g_pkg::A_RESET;
            r_e2        <= e2g_pkg::E2_RESET;
            r_max       <= e2g_pkg::IT_RESET;
            r_tol       <= e2g_pkg::TOL_RESET;
        end else begin
            // register writes
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    e2g_pkg::REG_SEMI_MAJOR: r_a   <= i_cfg.data[e2g_pkg::A_W-1:0];
                    e2g_pkg::REG_ECC_SQ:     r_e2  <= i_cfg.data[e2g_pkg::E2_W-1:0];
                    e2g_pkg::REG_MAX_ITER:   r_max <= i_cfg.data[e2g_pkg::IT_W-1:0];
                    e2g_pkg::REG_TOLERANCE:  r_tol <= i_cfg.data[e2g_pkg::TOL_W-1:0];
                    default: ;
                endcase
            end

            // result taken; a hand-over in S_HGT refills it instead
            if (r_out_valid && o_out.ready && (r_state != S_HGT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cx    <= {{4{i_in.x_mm[35]}}, i_in.x_mm, 20'd0};
                        r_cy    <= {{4{i_in.y_mm[35]}}, i_in.y_mm, 20'd0};
                        r_zz    <= {i_in.z_mm, 20'd0};
                        r_vec   <= 1'b1;
                        r_ret   <= S_LON_DONE;
                        r_k     <= '0;
                        r_conv  <= 1'b0;
                        r_iters <= (r_max == 4'd0) ? 4'd1 : r_max;
                        r_state <= S_VEC_PRE;
                    end
                end

                // fold the left half plane over, note the origin
                S_VEC_PRE: begin
                    r_vzero <= (r_cx == 60'sd0) && (r_cy == 60'sd0);
                    if (r_cx < 60'sd0) begin
                        r_cx <= -r_cx;
                        r_cy <= -r_cy;
                        r_cz <= 34'sh080000000;
                    end else begin
                        r_cz <= 34'sd0;
                    end
                    r_cnt   <= '0;
                    r_state <= S_CORDIC;
                end

                S_CORDIC: begin
                    r_cx <= n_cx;
                    r_cy <= n_cy;
                    r_cz <= n_cz;
                    if (r_cnt == 7'(e2g_pkg::CORDIC_STEPS - 1)) begin
                        r_state <= r_ret;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end

                S_MUL_LO: begin
                    r_pp_lo <= mul_p;
                    r_state <= S_MUL_HI;
                end

                S_MUL_HI: begin
                    r_pp_hi <= mul_p;
                    r_state <= S_MUL_ADD;
                end

                S_MUL_ADD: begin
                    r_prod  <= {32'd0, r_pp_lo} + {r_pp_hi, 32'd0};
                    r_state <= r_ret;
                end

                S_SQRT: begin
                    r_sq_v <= {r_sq_v[59:0], 2'b00};
                    if (sq_ge) begin
                        r_sq_rem  <= 33'(sq_sh - sq_trial);
                        r_sq_root <= {r_sq_root[29:0], 1'b1};
                    end else begin
                        r_sq_rem  <= sq_sh[32:0];
                        r_sq_root <= {r_sq_root[29:0], 1'b0};
                    end
                    if (r_cnt == 7'd30) begin
                        r_state <= r_ret;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end

                S_DIV: begin
                    r_dv_n   <= {r_dv_n[64:0], 1'b0};
                    r_dv_q   <= {r_dv_q[64:0], dv_ge};
                    r_dv_rem <= dv_ge ? dv_sub[30:0] : dv_t[30:0];
                    if (r_cnt == 7'd65) begin
                        r_state <= r_ret;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end

                // longitude, then magnitude times 1/K
                S_LON_DONE: begin
                    r_lon   <= r_vzero ? 32'd0 : r_cz[31:0];
                    r_ma    <= {4'd0, r_cx};
                    r_mb    <= {1'b0, e2g_pkg::INVK32};
                    r_ret   <= S_P_DONE;
                    r_state <= S_MUL_LO;
                end

                // first latitude estimate from atan2(z, p)
                S_P_DONE: begin
                    r_p     <= r_prod[87:32];
                    r_cx    <= {4'd0, r_prod[87:32]};
                    r_cy    <= {{4{r_zz[55]}}, r_zz};
                    r_vec   <= 1'b1;
                    r_ret   <= S_LAT_DONE;
                    r_state <= S_VEC_PRE;
                end

                S_LAT_DONE: begin
                    r_b     <= lat_ang;
                    r_state <= S_PASS;
                end

                // refinement pass: sine of the current latitude
                S_PASS: begin
                    r_passes <= r_k + 4'd1;
                    r_cx     <= {28'd0, e2g_pkg::INVK30};
                    r_cy     <= 60'sd0;
                    r_cz     <= {{2{r_b[31]}}, r_b};
                    r_vec    <= 1'b0;
                    r_cnt    <= '0;
                    r_ret    <= S_SC_DONE;
                    r_state  <= S_CORDIC;
                end

                S_SC_DONE: begin
                    r_sabs  <= sabs32[30:0];
                    r_sneg  <= sin_q[31];
                    r_ma    <= {33'd0, sabs32[30:0]};
                    r_mb    <= {2'd0, sabs32[30:0]};
                    r_ret   <= S_S2_DONE;
                    r_state <= S_MUL_LO;
                end

                S_S2_DONE: begin
                    r_ma    <= {33'd0, r_prod[60:30]};
                    r_mb    <= {7'd0, r_e2};
                    r_ret   <= S_T_DONE;
                    r_state <= S_MUL_LO;
                end

                // root of (1 - e2 sin^2) in Q30
                S_T_DONE: begin
                    r_sq_v    <= {1'b0, sq_w, 30'd0};
                    r_sq_rem  <= '0;
                    r_sq_root <= '0;
                    r_cnt     <= '0;
                    r_ret     <= S_Q_DONE;
                    r_state   <= S_SQRT;
                end

                S_Q_DONE: begin
                    r_dv_n   <= {5'd0, 1'b1, 60'd0};
                    r_dv_d   <= (r_sq_root == 31'd0) ? 31'd1 : r_sq_root;
                    r_dv_rem <= '0;
                    r_dv_q   <= '0;
                    r_cnt    <= '0;
                    r_ret    <= S_R_DONE;
                    r_state  <= S_DIV;
                end

                S_R_DONE: begin
                    r_ma    <= {41'd0, r_a};
                    r_mb    <= 33'd1000;
                    r_ret   <= S_AM_DONE;
                    r_state <= S_MUL_LO;
                end

                S_AM_DONE: begin
                    r_ma    <= {32'd0, r_dv_q[31:0]};
                    r_mb    <= r_prod[32:0];
                    r_ret   <= S_N_DONE;
                    r_state <= S_MUL_LO;
                end

                // radius N, then N * e2
                S_N_DONE: begin
                    r_n     <= r_prod[63:10];
                    r_ma    <= {10'd0, r_prod[63:10]};
                    r_mb    <= {7'd0, r_e2};
                    r_ret   <= S_M_DONE;
                    r_state <= S_MUL_LO;
                end

                S_M_DONE: begin
                    r_ma    <= {16'd0, r_prod[79:32]};
                    r_mb    <= {r_sabs, 2'b00};
                    r_ret   <= S_CORR_DONE;
                    r_state <= S_MUL_LO;
                end

                // new latitude from atan2(z + N e2 sin, p)
                S_CORR_DONE: begin
                    r_cx    <= {4'd0, r_p};
                    r_cy    <= {{3{num[56]}}, num};
                    r_vec   <= 1'b1;
                    r_ret   <= S_B1_DONE;
                    r_state <= S_VEC_PRE;
                end

                S_B1_DONE: begin
                    if (d_abs < $signed({25'd0, r_tol})) begin
                        r_conv  <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_b <= lat_ang;
                        if (r_k + 4'd1 == r_iters) begin
                            r_state <= S_FIN;
                        end else begin
                            r_k     <= r_k + 4'd1;
                            r_state <= S_PASS;
                        end
                    end
                end

                // cosine of the final latitude
                S_FIN: begin
                    r_cx    <= {28'd0, e2g_pkg::INVK30};
                    r_cy    <= 60'sd0;
                    r_cz    <= {{2{r_b[31]}}, r_b};
                    r_vec   <= 1'b0;
                    r_cnt   <= '0;
                    r_ret   <= S_FC_DONE;
                    r_state <= S_CORDIC;
                end

                // p / cos, saturated near the pole
                S_FC_DONE: begin
                    if (cos_q <= 32'sd0) begin
                        r_qv    <= (r_p == 56'd0) ? 38'd0 : LIMIT[37:0];
                        r_state <= S_HGT;
                    end else begin
                        r_dv_n   <= {r_p, 10'd0};
                        r_dv_d   <= cos_q[30:0];
                        r_dv_rem <= '0;
                        r_dv_q   <= '0;
                        r_cnt    <= '0;
                        r_ret    <= S_QC_DONE;
                        r_state  <= S_DIV;
                    end
                end

                S_QC_DONE: begin
                    r_qv    <= (r_dv_q > LIMIT) ? LIMIT[37:0] : r_dv_q[37:0];
                    r_state <= S_HGT;
                end

                // hand over once the output register is free
                S_HGT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_lat     <= r_b;
                        r_o_lon     <= r_lon;
                        r_o_hgt     <= hgt[35:0];
                        r_o_pass    <= r_passes;
                        r_o_conv    <= r_conv;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("request accepted while a conversion was running");

    a_cordic_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CORDIC |-> r_cnt < 7'(e2g_pkg::CORDIC_STEPS))
        else $error("CORDIC step count overran");

    a_lat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.latitude <= 32'sd1073741824)
                        && (o_out.latitude >= -32'sd1073741824))
        else $error("latitude outside a quarter turn");

    a_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.passes_used != 4'd0)
        else $error("result with no refinement pass");
`endif

endmodule

`default_nettype wire

// ----- test/ecef_to_geodetic_top_tb.sv -----
// ----------------------------------------------------------------------------
// ecef_to_geodetic_top_tb - self-checking bench for the ECEF to geodetic block
// Sends position requests through random gaps and result stalls. A bit-exact
// geodetic predictor queues the expected results. A checker compares each
// result, field by field, with the oldest expectation. Every register is
// swept across several settings, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecef_to_geodetic_top_tb;

    typedef struct packed {
        logic [e2g_pkg::ANG_W-1:0]  latitude;
        logic [e2g_pkg::ANG_W-1:0]  longitude;
        logic [e2g_pkg::HGT_W-1:0]  height_mm;
        logic [e2g_pkg::PASS_W-1:0] passes_used;
        logic                       converged;
    } t_geo_fix;

    localparam longint Q30_ONE = 64'sd1 << 30;
    localparam longint H_MAX   = (64'sd1 <<< 35) - 1;
    localparam longint H_MIN   = -(64'sd1 <<< 35);
    localparam longint unsigned QUOT_LIMIT = 64'd1 << 37;

    localparam longint ATAN_TAB [e2g_pkg::CORDIC_STEPS] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
        'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
        'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
        'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
        'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
        'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    e2g_in_if  pos_if ();
    e2g_out_if geo_if ();
    e2g_cfg_if cfg_if ();

    ecef_to_geodetic_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pos_if.sink),
        .o_out   (geo_if.source),
        .i_cfg   (cfg_if.sink)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the ellipsoid and loop registers
    longint unsigned axis_m, ecc_sq, iter_max, ang_tol;

    t_geo_fix fix_queue [$];
    int       n_errors = 0;
    bit       no_gaps  = 0;

    // ------------------------------------------------------------------
    // fixed-point helpers of the geodetic predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned mul_hi32(longint unsigned a, longint unsigned b);
        longint unsigned hi, lo;
        hi = (a >> 32) * b;
        lo = (a & 64'hFFFF_FFFF) * b;
        return hi + (lo >> 32);
    endfunction

    function automatic longint smul_hi32(longint unsigned a, longint b);
        longint unsigned m;
        m = mul_hi32(a, longint'(b < 0 ? -b : b));
        return b < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    // vectoring CORDIC: angle and gain-corrected magnitude
    function automatic void polar_of(input longint x, input longint y,
                                     output bit [31:0] ang, output longint unsigned mag);
        bit [31:0] z;
        longint dx, dy;
        z = 0;
        if (x == 0 && y == 0) begin
            ang = 0;
            mag = 0;
            return;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < e2g_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += ATAN_TAB[i][31:0];
            end else begin
                x -= dx; y += dy; z -= ATAN_TAB[i][31:0];
            end
        end
        ang = z;
        mag = mul_hi32(x, {32'd0, e2g_pkg::INVK32});
    endfunction

    function automatic void rot_sincos(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = longint'(e2g_pkg::INVK30);
        y = 0;
        z = ang;
        for (int i = 0; i < e2g_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        c = clip(x, -Q30_ONE, Q30_ONE);
        s = clip(y, -Q30_ONE, Q30_ONE);
    endfunction

    // prime-vertical radius, mm with 20 fraction bits
    function automatic longint unsigned prime_radius(longint s);
        longint unsigned s2, t, w, q, r;
        s2 = longint'(s * s) >> 30;
        t  = (ecc_sq * s2) >> 32;
        w  = (64'd1 << 30) - t;
        q  = int_sqrt(w << 30);
        if (q == 0) q = 1;
        r = (64'd1 << 60) / q;
        return (axis_m * 1000 * r) >> 10;
    endfunction

    function automatic longint geo_lat(longint num, longint p);
        bit [31:0] a;
        longint unsigned m;
        polar_of(p, num, a, m);
        return clip(longint'(signed'(a)), -Q30_ONE, Q30_ONE);
    endfunction

    // floor(p * 2^10 / c), saturating
    function automatic longint unsigned p_over_cos(longint unsigned p, longint c);
        longint unsigned den, q, r;
        if (c <= 0) return p == 0 ? 0 : QUOT_LIMIT;
        den = c;
        q = p / den;
        r = p % den;
        if (q > QUOT_LIMIT) return QUOT_LIMIT;
        for (int i = 0; i < 10; i++) begin
            r <<= 1;
            q <<= 1;
            if (r >= den) begin
                r -= den;
                q |= 1;
            end
            if (q > QUOT_LIMIT) return QUOT_LIMIT;
        end
        return q;
    endfunction

    function automatic t_geo_fix predict_fix(logic signed [e2g_pkg::COORD_W-1:0] xm,
                                             logic signed [e2g_pkg::COORD_W-1:0] ym,
                                             logic signed [e2g_pkg::COORD_W-1:0] zm);
        longint x, y, zz, b, b1, d, c, s, h;
        longint unsigned p, n, iters, passes, q;
        bit [31:0] lon;
        bit conv;
        t_geo_fix f;
        x  = longint'(xm) <<< e2g_pkg::FRAC_W;
        y  = longint'(ym) <<< e2g_pkg::FRAC_W;
        zz = longint'(zm) <<< e2g_pkg::FRAC_W;
        n = 0; passes = 0; conv = 0;
        polar_of(x, y, lon, p);
        b = geo_lat(zz, p);
        iters = iter_max == 0 ? 1 : iter_max;
        for (longint unsigned k = 0; k < iters; k++) begin
            passes = k + 1;
            rot_sincos(b, c, s);
            n  = prime_radius(s);
            b1 = geo_lat(zz + smul_hi32(mul_hi32(n, ecc_sq), s * 4), p);
            d  = b1 - b;
            if (d < 0) d = -d;
            if (d < longint'(ang_tol)) begin
                conv = 1;
                break;
            end
            b = b1;
        end
        rot_sincos(b, c, s);
        q = p_over_cos(p, c);
        h = clip(longint'(q) - longint'(n >> e2g_pkg::FRAC_W), H_MIN, H_MAX);
        f.latitude    = b[31:0];
        f.longitude   = lon;
        f.height_mm   = h[e2g_pkg::HGT_W-1:0];
        f.passes_used = passes[e2g_pkg::PASS_W-1:0];
        f.converged   = conv;
        return f;
    endfunction

    // ------------------------------------------------------------------
    // request and register drivers
    // ------------------------------------------------------------------
    task automatic send_pos(logic signed [e2g_pkg::COORD_W-1:0] xm,
                            logic signed [e2g_pkg::COORD_W-1:0] ym,
                            logic signed [e2g_pkg::COORD_W-1:0] zm);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            pos_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pos_if.valid <= 1'b1;
        pos_if.x_mm  <= xm;
        pos_if.y_mm  <= ym;
        pos_if.z_mm  <= zm;
        do @(posedge i_clk); while (!pos_if.ready);
        fix_queue = {fix_queue, predict_fix(xm, ym, zm)};
    endtask

    // registers change only with the block drained
    task automatic write_reg(logic [e2g_pkg::CFG_IDX_W-1:0] idx, longint unsigned val);
        pos_if.valid <= 1'b0;
        @(posedge i_clk);
        while (fix_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val[e2g_pkg::CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            e2g_pkg::REG_SEMI_MAJOR: axis_m   = val[e2g_pkg::A_W-1:0];
            e2g_pkg::REG_ECC_SQ:     ecc_sq   = val[e2g_pkg::E2_W-1:0];
            e2g_pkg::REG_MAX_ITER:   iter_max = val[e2g_pkg::IT_W-1:0];
            e2g_pkg::REG_TOLERANCE:  ang_tol  = val[e2g_pkg::TOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_ellipsoid(longint unsigned a, longint unsigned e2,
                                 longint unsigned it, longint unsigned tol);
        write_reg(e2g_pkg::REG_SEMI_MAJOR, a);
        write_reg(e2g_pkg::REG_ECC_SQ, e2);
        write_reg(e2g_pkg::REG_MAX_ITER, it);
        write_reg(e2g_pkg::REG_TOLERANCE, tol);
    endtask

    function automatic logic signed [e2g_pkg::COORD_W-1:0] rand_coord();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[e2g_pkg::COORD_W-1:0];
    endfunction

    // roughly earth-sized coordinate, about +-8000 km
    function automatic logic signed [e2g_pkg::COORD_W-1:0] rand_earth();
        longint v;
        v = longint'($urandom_range(0, 32'd2000000000)) * 4 - 64'sd4000000000;
        v = v * 2 + $urandom_range(0, 1);
        return v[e2g_pkg::COORD_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------
    task automatic test_special_points();
        logic signed [e2g_pkg::COORD_W-1:0] cmax, cmin;
        cmax = {1'b0, {(e2g_pkg::COORD_W-1){1'b1}}};
        cmin = {1'b1, {(e2g_pkg::COORD_W-1){1'b0}}};
        send_pos(0, 0, 0);                          // origin
        send_pos(-36'sd6378245000, 0, 0);           // negative x axis
        send_pos(36'sd6378245000, 0, 0);            // equator
        send_pos(0, 0, 36'sd6356863000);            // north pole
        send_pos(0, 0, -36'sd6356863000);           // south pole
        send_pos(0, 36'sd6378245000, 0);
        send_pos(cmax, cmax, cmax);
        send_pos(cmin, cmin, cmin);
        send_pos(cmax, cmin, 0);
        send_pos(cmin, 0, cmax);
        send_pos(1, -1, 1);
        send_pos(36'sd4000000000, 36'sd3000000000, 36'sd3500000000);
    endtask

    task automatic test_register_extremes();
        // zero iteration count acts as one pass
        set_ellipsoid(e2g_pkg::A_RESET, e2g_pkg::E2_RESET, 0, e2g_pkg::TOL_RESET);
        send_pos(36'sd4000000000, 36'sd3000000000, 36'sd3500000000);
        send_pos(0, 0, 36'sd6356863000);
        // zero tolerance: never converges
        set_ellipsoid(e2g_pkg::A_RESET, e2g_pkg::E2_RESET, 15, 0);
        send_pos(36'sd4000000000, -36'sd3000000000, 36'sd3500000000);
        // zero semi-major axis, upper bits of the write data ignored
        set_ellipsoid(32'hFF80_0000, 32'hFC00_0000, 1, 255);
        send_pos(36'sd4000000000, 36'sd3000000000, -36'sd3500000000);
        send_pos(0, 0, 0);
        set_ellipsoid(7000000, 67108863, 15, 0);
        send_pos(36'sd6000000000, 36'sd100000, 36'sd5000000000);
        send_pos(0, 0, -36'sd7000000000);
        set_ellipsoid(6000000, 0, 1, 255);
        send_pos(36'sd6000000000, 36'sd100000, 36'sd5000000000);
    endtask

    task automatic test_random_positions(int count);
        int mode;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 9);
            if (mode < 7)
                send_pos(rand_earth(), rand_earth(), rand_earth());
            else if (mode < 9)
                send_pos(rand_coord(), rand_coord(), rand_coord());
            else
                send_pos(0, 0, rand_coord());
        end
        no_gaps = 0;
    endtask

    task automatic test_random_settings();
        set_ellipsoid(e2g_pkg::A_RESET, e2g_pkg::E2_RESET, e2g_pkg::IT_RESET,
                      e2g_pkg::TOL_RESET);
        test_random_positions(500);
        set_ellipsoid(7000000, 67108863, 15, 0);
        test_random_positions(150);
        set_ellipsoid(6000000, 0, 1, 255);
        test_random_positions(150);
        set_ellipsoid($urandom_range(6000000, 7000000), $urandom_range(0, 67108863),
                      $urandom_range(1, 15), $urandom_range(0, 255));
        test_random_positions(350);
        set_ellipsoid($urandom_range(6000000, 7000000), $urandom_range(0, 67108863),
                      $urandom_range(1, 15), $urandom_range(0, 40));
        test_random_positions(350);
    endtask

    // ------------------------------------------------------------------
    // result stalls
    // ------------------------------------------------------------------
    initial begin
        int stall;
        geo_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                geo_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            geo_if.ready <= 1'b1;
            do @(posedge i_clk); while (!geo_if.valid);
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_geo_fix want;
        if (i_rst_n && geo_if.valid && geo_if.ready) begin
            if (fix_queue.size() == 0) begin
                n_errors++;
                $display("%t unexpected result: lat %h lon %h", $realtime,
                         geo_if.latitude, geo_if.longitude);
            end else begin
                want = fix_queue.pop_front();
                if (geo_if.latitude !== want.latitude) begin
                    n_errors++;
                    $display("%t latitude exp %h act %h", $realtime,
                             want.latitude, geo_if.latitude);
                end
                if (geo_if.longitude !== want.longitude) begin
                    n_errors++;
                    $display("%t longitude exp %h act %h", $realtime,
                             want.longitude, geo_if.longitude);
                end
                if (geo_if.height_mm !== want.height_mm) begin
                    n_errors++;
                    $display("%t height_mm exp %h act %h", $realtime,
                             want.height_mm, geo_if.height_mm);
                end
                if (geo_if.passes_used !== want.passes_used) begin
                    n_errors++;
                    $display("%t passes_used exp %h act %h", $realtime,
                             want.passes_used, geo_if.passes_used);
                end
                if (geo_if.converged !== want.converged) begin
                    n_errors++;
                    $display("%t converged exp %h act %h", $realtime,
                             want.converged, geo_if.converged);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      <= 1'b0;
        pos_if.valid <= 1'b0;
        pos_if.x_mm  <= '0;
        pos_if.y_mm  <= '0;
        pos_if.z_mm  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data  <= '0;
        axis_m   = e2g_pkg::A_RESET;
        ecc_sq   = e2g_pkg::E2_RESET;
        iter_max = e2g_pkg::IT_RESET;
        ang_tol  = e2g_pkg::TOL_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_points();
        test_register_extremes();
        test_random_settings();

        pos_if.valid <= 1'b0;
        while (fix_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial begin
        #400ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
